// File: src/prbll_pkg.sv
`timescale 1ns / 1ps
// prbll_pkg: shared widths, command codes and inter-module structs for the
// probit log likelihood accumulator. No dependencies.
package prbll_pkg;

  localparam int VALUE_W    = 16;
  localparam int COEF_IDX_W = 6;
  localparam int NF_W       = 7;
  localparam int PROD_W     = 32;
  localparam int ACC_W      = 40;
  localparam int TERM_W     = 20;
  localparam int TOTAL_W    = 48;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_FEATURE = 1'b1;

  localparam logic signed [TERM_W-1:0]  TERM_MIN  = {1'b1, {(TERM_W-1){1'b0}}};
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

  // finished row handed from the dot product to the lookup
  typedef struct packed {
    logic                    label;
    logic                    set_last;
    logic signed [ACC_W-1:0] dot;
  } prbll_row_t;

  // finished term handed from the lookup to the output stage
  typedef struct packed {
    logic signed [TERM_W-1:0] term;
    logic                     set_last;
  } prbll_term_t;

endpackage

// File: src/prbll_ifs.sv
`timescale 1ns / 1ps
// Channel interfaces: feature/load words in, result words out, config write.
// Depends on prbll_pkg for field widths.
interface prbll_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    command;
  logic [prbll_pkg::COEF_IDX_W-1:0]        coef_index;
  logic signed [prbll_pkg::VALUE_W-1:0]    value;
  logic                                    label;
  logic                                    set_last;

  modport source (output valid, command, coef_index, value, label, set_last, input ready);
  modport sink   (input valid, command, coef_index, value, label, set_last, output ready);
endinterface

interface prbll_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [prbll_pkg::TERM_W-1:0]     term;
  logic signed [prbll_pkg::TOTAL_W-1:0]    total;
  logic                                    set_done;

  modport source (output valid, term, total, set_done, input ready);
  modport sink   (input valid, term, total, set_done, output ready);
endinterface

interface prbll_cfg_if;
  logic                                    valid;
  logic                                    ready;
  logic [prbll_pkg::NF_W-1:0]              num_features;

  modport source (output valid, num_features, input ready);
  modport sink   (input valid, num_features, output ready);
endinterface

// File: src/prbll_dot.sv
`timescale 1ns / 1ps
// prbll_dot: coefficient store (sync-read memory), feature position and the
// saturating 40-bit dot accumulator. Uses prbll_pkg and prbll_in_if.
module prbll_dot #(
  parameter int MAX_FEATURES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  prbll_in_if.sink                      in_ch,
  input  logic [prbll_pkg::NF_W-1:0]    num_features,
  output logic                          row_valid,
  input  logic                          row_ready,
  output prbll_pkg::prbll_row_t         row
);

  localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CW = $clog2(MAX_FEATURES + 1);
  localparam int VW = prbll_pkg::VALUE_W;
  localparam int PW = prbll_pkg::PROD_W;
  localparam int AC = prbll_pkg::ACC_W;

  typedef struct packed {
    logic label;
    logic set_last;
    logic row_end;
  } flags_t;

  logic signed [VW-1:0] coef_mem [MAX_FEATURES];

  logic [CW-1:0]        pos_r;
  logic [CW-1:0]        cnt;
  logic [31:0]          nf_ext;
  logic [31:0]          cnt32;
  logic [CW:0]          pos_inc;
  logic                 row_end;

  logic                 v1_r, v2_r, v3_r;
  logic signed [VW-1:0] val1_r;
  logic signed [VW-1:0] coef1_r;
  flags_t               fl1_r, fl2_r;
  logic signed [PW-1:0] prod2_r;
  logic signed [AC-1:0] dot_r;
  logic signed [AC:0]   dot_sum;
  logic signed [AC-1:0] dot_nxt;
  prbll_pkg::prbll_row_t row_r;

  logic en1, en2, en3;
  logic acc_feat, acc_load;

  assign en3 = !v3_r || row_ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_ch.ready = en1;
  assign acc_feat = in_ch.valid && en1 && (in_ch.command == prbll_pkg::CMD_FEATURE);
  assign acc_load = in_ch.valid && en1 && (in_ch.command == prbll_pkg::CMD_LOAD);

  // effective row length: zero acts as one, clip at the store depth
  always_comb begin
    nf_ext = 32'(num_features);
    if (num_features == '0) begin
      cnt32 = 32'd1;
    end else if (nf_ext > 32'(MAX_FEATURES)) begin
      cnt32 = 32'(MAX_FEATURES);
    end else begin
      cnt32 = nf_ext;
    end
    cnt     = cnt32[CW-1:0];
    pos_inc = {1'b0, pos_r} + (CW+1)'(1);
    row_end = (pos_inc >= {1'b0, cnt});
  end

  // coefficient store: write on load, read the current position on feature
  always_ff @(posedge clk) begin
    if (acc_load && (32'(in_ch.coef_index) < 32'(MAX_FEATURES))) begin
      coef_mem[AW'(in_ch.coef_index)] <= in_ch.value;
    end
    if (acc_feat) begin
      coef1_r <= coef_mem[pos_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (acc_feat) begin
      pos_r <= row_end ? '0 : pos_inc[CW-1:0];
    end
  end

  // stage 1: hold the feature next to its coefficient read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= acc_feat;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_feat) begin
      val1_r <= in_ch.value;
      fl1_r  <= '{label: in_ch.label, set_last: in_ch.set_last, row_end: row_end};
    end
  end

  // stage 2: product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      prod2_r <= val1_r * coef1_r;
      fl2_r   <= fl1_r;
    end
  end

  // stage 3: accumulate with saturation, drop the row on its last feature
  always_comb begin
    dot_sum = {dot_r[AC-1], dot_r} + {{(AC+1-PW){prod2_r[PW-1]}}, prod2_r};
    if (dot_sum[AC] != dot_sum[AC-1]) begin
      dot_nxt = dot_sum[AC] ? {1'b1, {(AC-1){1'b0}}} : {1'b0, {(AC-1){1'b1}}};
    end else begin
      dot_nxt = dot_sum[AC-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0;
      v3_r  <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r && fl2_r.row_end;
      if (v2_r) begin
        dot_r <= fl2_r.row_end ? '0 : dot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r && fl2_r.row_end) begin
      row_r <= '{label: fl2_r.label, set_last: fl2_r.set_last, dot: dot_nxt};
    end
  end

  assign row_valid = v3_r;
  assign row       = row_r;

endmodule

// File: src/prbll_logphi.sv
`timescale 1ns / 1ps
// prbll_logphi: clamp, table index, table read and linear interpolation of
// log Phi(z). The table is built at elaboration. Uses prbll_pkg.
module prbll_logphi #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    row_valid,
  output logic                    row_ready,
  input  prbll_pkg::prbll_row_t   row,
  output logic                    term_valid,
  input  logic                    term_ready,
  output prbll_pkg::prbll_term_t  term
);

  localparam int TW    = prbll_pkg::TERM_W;
  localparam int AC    = prbll_pkg::ACC_W;
  localparam int UW    = 28;
  localparam int IW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LW    = $clog2(TABLE_DEPTH + 1);
  localparam int MW    = UW + LW;
  localparam int LUT_W = (TABLE_DEPTH + 1) * TW;
  localparam int FRAC_B = 26;
  localparam longint STEP_Q  = 64'sd262144;
  localparam longint START_H = 64'sd545015781;
  localparam longint START_L = -64'sd2349711995;

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] h;
    logic signed [63:0] l;
  } ode_t;

  function automatic longint rshift_rnd(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return rshift_rnd(a * b, FRAC_B);
  endfunction

  function automatic longint slope(longint x, longint h);
    return -(qmul(x, h) + qmul(h, h));
  endfunction

  // one RK4 step of H' = -xH - H^2, L' = H
  function automatic ode_t rk_step(ode_t st, longint s);
    longint half, h1, k1, h2, k2, h3, k3, h4, k4;
    ode_t r;
    half = s >>> 1;
    h1 = st.h;
    k1 = slope(st.x, h1);
    h2 = st.h + qmul(half, k1);
    k2 = slope(st.x + half, h2);
    h3 = st.h + qmul(half, k2);
    k3 = slope(st.x + half, h3);
    h4 = st.h + qmul(s, k3);
    k4 = slope(st.x + s, h4);
    r.l = st.l + qmul(s, h1 + 2 * h2 + 2 * h3 + h4) / 6;
    r.h = st.h + qmul(s, k1 + 2 * k2 + 2 * k3 + k4) / 6;
    r.x = st.x + s;
    return r;
  endfunction

  function automatic logic [LUT_W-1:0] build_lut();
    ode_t st;
    longint tgt, v;
    logic [LUT_W-1:0] bits;
    int i;
    st.x = -(longint'(8) <<< FRAC_B);
    st.h = START_H;
    st.l = START_L;
    bits = '0;
    for (i = 0; i <= TABLE_DEPTH; i++) begin
      tgt = -(longint'(8) <<< FRAC_B) + (longint'(16 * i) <<< FRAC_B) / TABLE_DEPTH;
      while (tgt - st.x >= STEP_Q) begin
        st = rk_step(st, STEP_Q);
      end
      if (tgt > st.x) begin
        st = rk_step(st, tgt - st.x);
      end
      v = rshift_rnd(st.l, FRAC_B - 12);
      if (v > 0) begin
        v = 0;
      end
      bits[i*TW +: TW] = v[TW-1:0];
    end
    return bits;
  endfunction

  localparam logic [LUT_W-1:0] LUT_BITS = build_lut();

  localparam logic signed [AC:0] ZLO = -(AC+1)'(134217728);
  localparam logic signed [AC:0] ZHI = (AC+1)'(134217727);

  logic en4, en5, en6, en7;
  logic v4_r, v5_r, v6_r, v7_r;

  logic signed [AC:0]   z_full;
  logic signed [AC:0]   z_sel;
  logic signed [AC:0]   z_off;
  logic [UW-1:0]        u_nxt;
  logic [UW-1:0]        u4_r;
  logic                 last4_r, last5_r, last6_r;

  logic [MW-1:0]        pmul;
  logic [IW-1:0]        idx5_r;
  logic [UW-1:0]        frac5_r, frac6_r;

  logic [LW-1:0]        idx_lo, idx_hi;
  logic signed [TW-1:0] lut_lo, lut_hi;
  logic signed [TW-1:0] lo6_r;
  logic signed [TW:0]   diff6_r;

  logic signed [50:0]   interp;
  logic signed [50:0]   interp_rnd;
  logic signed [22:0]   interp_q;
  logic signed [TW-1:0] term_nxt;
  prbll_pkg::prbll_term_t term_r;

  assign en7 = !v7_r || term_ready;
  assign en6 = !v6_r || en7;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign row_ready = en4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (en4) v4_r <= row_valid;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
      if (en7) v7_r <= v6_r;
    end
  end

  // stage 4: sign by label, clamp to [-8, 8) and offset to an unsigned Q.24
  always_comb begin
    z_full = {row.dot[AC-1], row.dot};
    z_sel  = row.label ? z_full : -z_full;
    z_off  = z_sel - ZLO;
    if (z_sel < ZLO) begin
      u_nxt = '0;
    end else if (z_sel > ZHI) begin
      u_nxt = '1;
    end else begin
      u_nxt = z_off[UW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && row_valid) begin
      u4_r    <= u_nxt;
      last4_r <= row.set_last;
    end
  end

  // stage 5: scale by the table depth into index and fraction
  assign pmul = MW'(u4_r) * MW'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (en5 && v4_r) begin
      idx5_r  <= pmul[UW +: IW];
      frac5_r <= pmul[UW-1:0];
      last5_r <= last4_r;
    end
  end

  // stage 6: read both neighbors
  always_comb begin
    idx_lo = LW'(idx5_r);
    idx_hi = idx_lo + LW'(1);
    lut_lo = $signed(LUT_BITS[32'(idx_lo) * TW +: TW]);
    lut_hi = $signed(LUT_BITS[32'(idx_hi) * TW +: TW]);
  end

  always_ff @(posedge clk) begin
    if (en6 && v5_r) begin
      lo6_r   <= lut_lo;
      diff6_r <= {lut_hi[TW-1], lut_hi} - {lut_lo[TW-1], lut_lo};
      frac6_r <= frac5_r;
      last6_r <= last5_r;
    end
  end

  // stage 7: interpolate, round and clamp to [TERM_MIN, 0]
  always_comb begin
    interp = {{3{lo6_r[TW-1]}}, lo6_r, {UW{1'b0}}}
           + 51'(diff6_r * $signed({1'b0, frac6_r}));
    interp_rnd = interp + (51'sd1 <<< (UW - 1));
    interp_q   = interp_rnd[50:UW];
    if (interp_q > 23'sd0) begin
      term_nxt = '0;
    end else if (interp_q < 23'(prbll_pkg::TERM_MIN)) begin
      term_nxt = prbll_pkg::TERM_MIN;
    end else begin
      term_nxt = interp_q[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en7 && v6_r) begin
      term_r <= '{term: term_nxt, set_last: last6_r};
    end
  end

  assign term_valid = v7_r;
  assign term       = term_r;

endmodule

// File: src/probit_log_likelihood_accumulator.sv
`timescale 1ns / 1ps
// probit_log_likelihood_accumulator: top level. Holds the feature count
// register, the running total and the result word register.
// Depends on prbll_pkg, prbll_ifs, prbll_dot and prbll_logphi.
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    command, coef_index, value, label, set_last
//  out_ch   out  valid/ready    term, total, set_done
//  cfg_ch   in   valid/ready    num_features (ready held high)
//
// One word is taken per cycle while in_ch.ready is high; the dot product runs read, multiply and
// accumulate in three stages behind the coefficient memory port.
// A row's result word passes dot stages 1 to 3, lookup stages 4 to 7 and the output register.
// Reset is synchronous; the table is constant logic and the coefficient
// store needs no clearing, so words are taken from the first cycle.
// A stalled result holds the pipeline; in_ch.ready drops once it fills.
module probit_log_likelihood_accumulator #(
  parameter int MAX_FEATURES = 64,
  parameter int TABLE_DEPTH  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  prbll_in_if.sink    in_ch,
  prbll_out_if.source out_ch,
  prbll_cfg_if.sink   cfg_ch
);

  localparam int TW = prbll_pkg::TERM_W;
  localparam int OW = prbll_pkg::TOTAL_W;

  logic [prbll_pkg::NF_W-1:0] nf_r;

  logic                   row_valid, row_ready;
  prbll_pkg::prbll_row_t  row;
  logic                   term_valid, term_ready;
  prbll_pkg::prbll_term_t term;

  logic signed [OW-1:0]   total_r;
  logic signed [OW:0]     sum;
  logic signed [OW-1:0]   total_nxt;
  logic                   out_valid_r;
  logic signed [TW-1:0]   out_term_r;
  logic signed [OW-1:0]   out_total_r;
  logic                   out_done_r;
  logic                   en_o;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nf_r <= prbll_pkg::NF_W'(1);
    end else if (cfg_ch.valid) begin
      nf_r <= cfg_ch.num_features;
    end
  end

  prbll_dot #(
    .MAX_FEATURES (MAX_FEATURES)
  ) u_dot (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .num_features (nf_r),
    .row_valid    (row_valid),
    .row_ready    (row_ready),
    .row          (row)
  );

  prbll_logphi #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_logphi (
    .clk        (clk),
    .rst_n      (rst_n),
    .row_valid  (row_valid),
    .row_ready  (row_ready),
    .row        (row),
    .term_valid (term_valid),
    .term_ready (term_ready),
    .term       (term)
  );

  assign en_o       = !out_valid_r || out_ch.ready;
  assign term_ready = en_o;

  // terms are never positive, so the sum only saturates at the bottom
  always_comb begin
    sum = {total_r[OW-1], total_r} + {{(OW+1-TW){term.term[TW-1]}}, term.term};
    if (sum[OW] && !sum[OW-1]) begin
      total_nxt = prbll_pkg::TOTAL_MIN;
    end else begin
      total_nxt = sum[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (en_o) begin
      out_valid_r <= term_valid;
      if (term_valid) begin
        total_r <= term.set_last ? '0 : total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_o && term_valid) begin
      out_term_r  <= term.term;
      out_total_r <= total_nxt;
      out_done_r  <= term.set_last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.term     = out_term_r;
  assign out_ch.total    = out_total_r;
  assign out_ch.set_done = out_done_r;

endmodule
